[design/plc_pkg.sv]
// Package for the positional list engine.
// Holds widths, command and status codes, payload structs and cell control.
// No dependencies.
package plc_pkg;

  // List capacity and derived widths
  localparam int DEPTH = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int POS_W = 6;
  localparam int LEN_W = 6;
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // Command codes
  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_DEL_FRONT = 3'd2,
    CMD_DEL_BACK  = 3'd3,
    CMD_INS_AT    = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_COUNT     = 3'd6,
    CMD_SHOW      = 3'd7
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_SHOW
  } state_t;

  // Per-cycle operation broadcast to every cell
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [CNT_W-1:0]   idx;   // target slot of insert or remove
    logic [CNT_W-1:0]   tail;  // slot of the last element, for rotate
  } cell_ctrl_t;

  // Input item
  typedef struct packed {
    cmd_t                     cmd;
    logic signed [VAL_W-1:0]  value;
    logic [POS_W-1:0]         position;
  } command_t;

  // Result item
  typedef struct packed {
    logic signed [VAL_W-1:0]  element;
    logic [LEN_W-1:0]         length;
    status_t                  status;
    logic                     last;
  } result_t;

endpackage

[design/plc_cell.sv]
// One storage cell of the list chain.
// Takes its left or right neighbor, the new value or the head value per command.
// Depends on plc_pkg.
module plc_cell import plc_pkg::*; (
  input  logic                    clk,
  input  cell_ctrl_t              ctrl,
  input  logic [CNT_W-1:0]        slot,
  input  logic signed [VAL_W-1:0] ins_val,
  input  logic signed [VAL_W-1:0] left_val,
  input  logic signed [VAL_W-1:0] right_val,
  input  logic signed [VAL_W-1:0] head_val,
  output logic signed [VAL_W-1:0] val
);

  logic signed [VAL_W-1:0] val_next;

  // Pick the next content from the broadcast operation
  always_comb begin
    val_next = val;
    unique case (ctrl.op)
      CELL_HOLD: begin
        val_next = val;
      end
      CELL_INSERT: begin
        if (slot == ctrl.idx) begin
          val_next = ins_val;
        end else if (slot > ctrl.idx) begin
          val_next = left_val;
        end
      end
      CELL_REMOVE: begin
        if (slot >= ctrl.idx) begin
          val_next = right_val;
        end
      end
      CELL_ROTATE: begin
        // wrap the head around to the tail, advance everything else
        if (slot == ctrl.tail) begin
          val_next = head_val;
        end else begin
          val_next = right_val;
        end
      end
      default: begin
        val_next = val;
      end
    endcase
  end

  // Hold the element
  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

[design/positional_list_engine_unit.sv]
// Positional list engine: an ordered list held in a chain of storage cells,
// with a command decoder and display sequencer. Depends on plc_pkg, plc_cell.
//
// Every command except display of a non-empty list is taken at once: busy
// stays low, a new item may follow on the next clock, and its single result
// appears with done high in the cycle after acceptance. Inserts and deletes at
// any position need no sequencing because every cell shifts toward or away from
// its neighbor at once. Display of a non-empty list holds busy high while it
// emits one element per cycle, head first, by rotating the occupied part of the
// chain; once every element has been emitted the chain is back in order.
// Results are presented for exactly one cycle and cannot be stalled.
module positional_list_engine_unit import plc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  command_t command,
  output logic     busy,
  output logic     done,
  output result_t  result
);

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] remaining, remaining_next;
  logic             done_next;
  result_t          result_next;
  cell_ctrl_t       ctrl;
  status_t          status;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] pos_m1;
  logic             full;
  logic             empty;

  logic signed [VAL_W-1:0] cell_val [DEPTH];

  // Build the chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_v;
    logic signed [VAL_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = command.value;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_v = cell_val[i];
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end
    plc_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .slot      (CNT_W'(i)),
      .ins_val   (command.value),
      .left_val  (left_v),
      .right_val (right_v),
      .head_val  (cell_val[0]),
      .val       (cell_val[i])
    );
  end

  assign busy    = (state == S_SHOW);
  assign pos_ext = CMP_W'(command.position);
  assign cnt_ext = CMP_W'(count);
  assign pos_m1  = pos_ext - CMP_W'(1);
  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);

  // Decode commands and sequence the display
  always_comb begin
    state_next     = state;
    count_next     = count;
    remaining_next = remaining;
    done_next      = 1'b0;
    status         = STAT_OK;
    result_next    = '0;
    ctrl.op        = CELL_HOLD;
    ctrl.idx       = '0;
    ctrl.tail      = count - CNT_W'(1);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          done_next        = 1'b1;
          result_next.last = 1'b1;
          unique case (command.cmd)
            CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
              if (full) begin
                status = STAT_FULL;
              end else if (command.cmd == CMD_INS_AT &&
                           (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1))) begin
                status = STAT_RANGE;
              end else begin
                ctrl.op    = CELL_INSERT;
                count_next = count + CNT_W'(1);
                if (command.cmd == CMD_INS_FRONT) begin
                  ctrl.idx = '0;
                end else if (command.cmd == CMD_INS_BACK) begin
                  ctrl.idx = count;
                end else begin
                  ctrl.idx = CNT_W'(pos_m1);
                end
              end
            end
            CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT: begin
              if (empty) begin
                status = STAT_EMPTY;
              end else if (command.cmd == CMD_DEL_AT &&
                           (pos_ext == '0 || pos_ext > cnt_ext)) begin
                status = STAT_RANGE;
              end else begin
                ctrl.op    = CELL_REMOVE;
                count_next = count - CNT_W'(1);
                if (command.cmd == CMD_DEL_FRONT) begin
                  ctrl.idx = '0;
                end else if (command.cmd == CMD_DEL_BACK) begin
                  ctrl.idx = count - CNT_W'(1);
                end else begin
                  ctrl.idx = CNT_W'(pos_m1);
                end
              end
            end
            CMD_COUNT: begin
              status = STAT_OK;
            end
            CMD_SHOW: begin
              if (empty) begin
                status = STAT_EMPTY;
              end else begin
                // stream from the next cycle on
                done_next        = 1'b0;
                result_next.last = 1'b0;
                remaining_next   = count;
                state_next       = S_SHOW;
              end
            end
            default: begin
              status = STAT_OK;
            end
          endcase
        end
      end
      S_SHOW: begin
        // emit the head and rotate the occupied cells
        done_next           = 1'b1;
        result_next.element = cell_val[0];
        result_next.last    = (remaining == CNT_W'(1));
        ctrl.op             = CELL_ROTATE;
        remaining_next      = remaining - CNT_W'(1);
        if (remaining == CNT_W'(1)) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    result_next.status = status;
    result_next.length = LEN_W'(count_next);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      remaining <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      remaining <= remaining_next;
      done      <= done_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    result <= result_next;
  end

  // Count never exceeds capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("element count above capacity");

  // A single-result command answers next cycle with a final item
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command.cmd != CMD_SHOW) |=> (done && result.last))
    else $error("missing single result");

  // A command moves the count by at most one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (count == $past(count) ||
                          count == $past(count) + CNT_W'(1) ||
                          count == $past(count) - CNT_W'(1)))
    else $error("count changed by more than one");

  // The display ends with a final item and returns to idle
  a_show_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHOW && remaining == CNT_W'(1)) |=>
      (done && result.last && state == S_IDLE))
    else $error("display did not end cleanly");

  // Display leaves the count untouched
  a_show_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHOW) |=> $stable(count))
    else $error("count changed during display");

endmodule

[sim/positional_list_engine_unit_test.sv]
// Testbench for positional_list_engine_unit: directed table, then random phases.
// Predicts results from its own copy of the list, or takes them from the directed
// table, and checks them on the fly. Depends on plc_pkg and the RTL of positional_list_engine_unit.
module positional_list_engine_unit_test;
  import plc_pkg::*;

  // Expected result typed into the directed table, or taken from the predictor
  typedef struct {
    bit      known;
    result_t res;
  } pin_t;

  typedef struct {
    command_t item;
    pin_t     check;
  } row_t;

  logic     clk;
  logic     rst;
  logic     start;
  command_t command;
  logic     busy;
  logic     done;
  result_t  result;

  // Predicted list contents and results still to come
  logic [VAL_W-1:0] list_vals [0:DEPTH-1];
  int               list_len;
  result_t          step_out [$];
  result_t          pending [$];
  pin_t             pinned [$];
  int               fault_count;
  result_t          want;
  pin_t             pin_now;

  positional_list_engine_unit dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Shift entries up and store the value at idx
  function automatic void list_insert(int idx, logic [VAL_W-1:0] v);
    for (int i = list_len; i > idx; i--) list_vals[i] = list_vals[i-1];
    list_vals[idx] = v;
    list_len++;
  endfunction

  // Close the gap left by the entry at idx
  function automatic void list_remove(int idx);
    for (int i = idx; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
    list_len--;
  endfunction

  function automatic result_t make_result(logic [VAL_W-1:0] e, status_t st, logic lst);
    result_t r;
    r.element = e;
    r.length  = LEN_W'(list_len);
    r.status  = st;
    r.last    = lst;
    return r;
  endfunction

  // Apply one command to the list and leave its results in step_out
  function automatic void list_step(command_t c);
    status_t st;
    int      pos;
    st  = STAT_OK;
    pos = int'(c.position);
    step_out = {};
    case (c.cmd)
      CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
        // full list is checked before the position
        if (list_len >= DEPTH) st = STAT_FULL;
        else if (c.cmd == CMD_INS_FRONT) list_insert(0, c.value);
        else if (c.cmd == CMD_INS_BACK) list_insert(list_len, c.value);
        else if (pos < 1 || pos > list_len + 1) st = STAT_RANGE;
        else list_insert(pos - 1, c.value);
      end
      CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT: begin
        // empty list is checked before the position
        if (list_len == 0) st = STAT_EMPTY;
        else if (c.cmd == CMD_DEL_FRONT) list_remove(0);
        else if (c.cmd == CMD_DEL_BACK) list_remove(list_len - 1);
        else if (pos < 1 || pos > list_len) st = STAT_RANGE;
        else list_remove(pos - 1);
      end
      CMD_COUNT: ;
      default: begin
        // display: one item per element, or a single empty marker
        if (list_len == 0) begin
          step_out.push_back(make_result('0, STAT_EMPTY, 1'b1));
        end else begin
          for (int k = 0; k < list_len; k++)
            step_out.push_back(make_result(list_vals[k], STAT_OK, k == list_len - 1));
        end
        return;
      end
    endcase
    step_out.push_back(make_result('0, st, 1'b1));
  endfunction

  task automatic log_fault(string msg);
    fault_count++;
    if (fault_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // Check accepted results, then predict for an accepted item
  always @(posedge clk) begin
    if (!rst) begin
      if (done === 1'b1) begin
        if (pending.size() == 0) begin
          log_fault($sformatf("unexpected result: element=%0d length=%0d status=%0d last=%0d",
                              result.element, result.length, result.status, result.last));
        end else begin
          want = pending.pop_front();
          if (result.element !== want.element || result.length !== want.length ||
              result.status !== want.status || result.last !== want.last)
            log_fault($sformatf({"mismatch: expected element=%0d length=%0d status=%0d ",
                                 "last=%0d, got element=%0d length=%0d status=%0d last=%0d"},
                                want.element, want.length, want.status, want.last,
                                result.element, result.length, result.status, result.last));
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        list_step(command);
        pin_now.known = 1'b0;
        if (pinned.size() != 0) pin_now = pinned.pop_front();
        if (pin_now.known) pending.push_back(pin_now.res);
        else foreach (step_out[i]) pending.push_back(step_out[i]);
      end
    end
  end

  // Drive one item, idling first at random; return at the edge that takes it
  task automatic issue(command_t c, int idle_pct, pin_t pin);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    pinned.push_back(pin);
    @(negedge clk);
    start   <= 1'b1;
    command <= c;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Hold off until every predicted result has come, with a bound
  task automatic wait_idle();
    int spins;
    spins = 0;
    @(negedge clk);
    start <= 1'b0;
    while (pending.size() != 0 && spins < 5000) begin
      @(posedge clk);
      spins++;
    end
  endtask

  function automatic command_t next_item(int ins_pct, int del_pct);
    command_t c;
    int       r;
    r = $urandom_range(99);
    if (r < ins_pct) begin
      case ($urandom_range(2))
        0:       c.cmd = CMD_INS_FRONT;
        1:       c.cmd = CMD_INS_BACK;
        default: c.cmd = CMD_INS_AT;
      endcase
    end else if (r < ins_pct + del_pct) begin
      case ($urandom_range(2))
        0:       c.cmd = CMD_DEL_FRONT;
        1:       c.cmd = CMD_DEL_BACK;
        default: c.cmd = CMD_DEL_AT;
      endcase
    end else begin
      c.cmd = ($urandom_range(1) == 0) ? CMD_COUNT : CMD_SHOW;
    end
    // mix in the value extremes now and then
    case ($urandom_range(7))
      0:       c.value = 32'h8000_0000;
      1:       c.value = 32'h7FFF_FFFF;
      2:       c.value = 32'hFFFF_FFFF;
      default: c.value = $urandom;
    endcase
    // mostly near the valid range, sometimes anywhere
    if ($urandom_range(7) == 0) c.position = POS_W'($urandom_range(63));
    else c.position = POS_W'($urandom_range(list_len + 2));
    return c;
  endfunction

  function automatic row_t row(cmd_t c, logic [VAL_W-1:0] v, logic [POS_W-1:0] p,
                               bit known, logic [LEN_W-1:0] len, status_t st);
    row_t r;
    r.item.cmd          = c;
    r.item.value        = v;
    r.item.position     = p;
    r.check.known       = known;
    r.check.res.element = '0;
    r.check.res.length  = len;
    r.check.res.status  = st;
    r.check.res.last    = 1'b1;
    return r;
  endfunction

  task automatic run_phase(int n, int ins_pct, int del_pct, int idle_pct);
    pin_t loose;
    loose.known = 1'b0;
    loose.res   = '0;
    repeat (n) issue(next_item(ins_pct, del_pct), idle_pct, loose);
  endtask

  row_t plan [$];

  initial begin
    pin_t     loose;
    command_t c;
    int       full_hits;
    int       guard;

    loose.known = 1'b0;
    loose.res   = '0;
    fault_count = 0;
    list_len    = 0;
    rst         = 1'b1;
    start       = 1'b0;
    command     = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty-list errors, range edges, extremes, last-position delete
    plan.push_back(row(CMD_COUNT,     32'h0,         6'd0,  1, 6'd0, STAT_OK));
    plan.push_back(row(CMD_SHOW,      32'h0,         6'd0,  1, 6'd0, STAT_EMPTY));
    plan.push_back(row(CMD_DEL_FRONT, 32'h0,         6'd0,  1, 6'd0, STAT_EMPTY));
    plan.push_back(row(CMD_DEL_BACK,  32'h0,         6'd0,  1, 6'd0, STAT_EMPTY));
    plan.push_back(row(CMD_DEL_AT,    32'h0,         6'd0,  1, 6'd0, STAT_EMPTY));
    plan.push_back(row(CMD_INS_AT,    32'h1,         6'd0,  1, 6'd0, STAT_RANGE));
    plan.push_back(row(CMD_INS_AT,    32'h1,         6'd2,  1, 6'd0, STAT_RANGE));
    plan.push_back(row(CMD_INS_AT,    32'h7FFF_FFFF, 6'd1,  1, 6'd1, STAT_OK));
    plan.push_back(row(CMD_INS_FRONT, 32'h8000_0000, 6'd0,  1, 6'd2, STAT_OK));
    plan.push_back(row(CMD_INS_BACK,  32'hFFFF_FFFF, 6'd0,  1, 6'd3, STAT_OK));
    plan.push_back(row(CMD_INS_AT,    32'h0,         6'd4,  1, 6'd4, STAT_OK));
    plan.push_back(row(CMD_INS_AT,    32'h5555_5555, 6'd2,  1, 6'd5, STAT_OK));
    plan.push_back(row(CMD_SHOW,      32'h0,         6'd0,  0, 6'd0, STAT_OK));
    plan.push_back(row(CMD_DEL_AT,    32'h0,         6'd6,  1, 6'd5, STAT_RANGE));
    plan.push_back(row(CMD_DEL_AT,    32'h0,         6'd63, 1, 6'd5, STAT_RANGE));
    plan.push_back(row(CMD_INS_AT,    32'hAAAA_AAAA, 6'd63, 1, 6'd5, STAT_RANGE));
    plan.push_back(row(CMD_DEL_AT,    32'h0,         6'd5,  1, 6'd4, STAT_OK));
    plan.push_back(row(CMD_DEL_AT,    32'h0,         6'd2,  1, 6'd3, STAT_OK));
    plan.push_back(row(CMD_DEL_FRONT, 32'h0,         6'd0,  1, 6'd2, STAT_OK));
    plan.push_back(row(CMD_DEL_BACK,  32'h0,         6'd0,  1, 6'd1, STAT_OK));
    plan.push_back(row(CMD_SHOW,      32'h0,         6'd0,  0, 6'd0, STAT_OK));
    plan.push_back(row(CMD_DEL_AT,    32'h0,         6'd1,  1, 6'd0, STAT_OK));
    plan.push_back(row(CMD_SHOW,      32'h0,         6'd0,  1, 6'd0, STAT_EMPTY));
    plan.push_back(row(CMD_COUNT,     32'h0,         6'd0,  1, 6'd0, STAT_OK));
    foreach (plan[i]) issue(plan[i].item, 0, plan[i].check);
    wait_idle();

    // Fill toward capacity and keep pushing against the full list
    full_hits = 0;
    guard     = 0;
    while (full_hits < 10 && guard < 150) begin
      if (list_len == DEPTH) full_hits++;
      issue(next_item(80, 10), 0, loose);
      guard++;
    end
    c.cmd      = CMD_SHOW;
    c.value    = '0;
    c.position = '0;
    issue(c, 0, loose);
    // pause the sender until everything has drained
    wait_idle();

    // Balanced traffic with a mostly idle sender
    run_phase(30, 45, 40, 79);
    wait_idle();
    // Drain toward empty; results cannot be stalled, so no sender idling here
    run_phase(30, 10, 80, 0);
    wait_idle();
    // Balanced traffic with light idling
    run_phase(30, 45, 40, 9);

    // Let the last results arrive, then settle
    wait_idle();
    repeat (4) @(posedge clk);
    if (pending.size() != 0)
      log_fault($sformatf("%0d expected results never arrived", pending.size()));

    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop in case the block hangs
  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[positional_list_engine_unit.f]
design/plc_pkg.sv
design/plc_cell.sv
design/positional_list_engine_unit.sv
sim/positional_list_engine_unit_test.sv
